### rtl/core/bfra_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfra_pkg
// Shared types and codes for the best-fit range allocator.
// ---------------------------------------------------------------------------
package bfra_pkg;

   localparam int DEFAULT_MAX_RANGES = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic CSR_BASE = 1'b0;
   localparam logic CSR_SIZE = 1'b1;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } entry_type;

endpackage
`default_nettype wire

### rtl/core/bfra_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfra_table
// Free range table: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bfra_table import bfra_pkg::*; #(
   parameter int DEPTH = DEFAULT_MAX_RANGES,
   localparam int IW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_idx,
   input  wire entry_type     wr_data,
   input  wire logic [IW-1:0] rd_idx,
   output entry_type          rd_data
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end

endmodule
`default_nettype wire

### rtl/core/best_fit_range_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// best_fit_range_allocator
// Best-fit allocator over an address-sorted table of free ranges.
// ---------------------------------------------------------------------------
// Pulse start while busy is low to launch an allocate or a free. The answer
// word appears on the rsp_ ports for one cycle with rsp_valid, which cannot be
// held off; busy is high while an operation runs, and a new start may be taken
// in the cycle the answer word is shown. Every table access goes through the
// table memory's one read port and one write port: a scan reads each entry in
// a read state and an evaluate state, and each entry moved when a range is
// inserted or removed takes a read state and a write state.
// ---------------------------------------------------------------------------
module best_fit_range_allocator import bfra_pkg::*; #(
   parameter int MAX_RANGES = DEFAULT_MAX_RANGES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] req_address,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_address_res
);

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_INIT      = 12'b000000000010,
      S_SCAN_RD   = 12'b000000000100,
      S_SCAN_EV   = 12'b000000001000,
      S_FREE_LAST = 12'b000000010000,
      S_ALLOC_END = 12'b000000100000,
      S_WRITE     = 12'b000001000000,
      S_RM_BEGIN  = 12'b000010000000,
      S_RM_RD     = 12'b000100000000,
      S_RM_WR     = 12'b001000000000,
      S_INS_RD    = 12'b010000000000,
      S_INS_WR    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic            done_ff, done_in;
   logic [31:0]     base_ff, size_cfg_ff;
   logic            init_ff, init_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic            pos_found_ff, pos_found_in;
   logic            op_ff, op_in;
   logic [31:0]     size_ff, size_in, addr_ff, addr_in, end_ff, end_in;
   entry_type       prev_ff, prev_in, cur_ff, cur_in, best_ff, best_in;
   logic [IW-1:0]   best_idx_ff, best_idx_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   k_ff, k_in, rm_idx_ff, rm_idx_in, wr_idx_ff, wr_idx_in;
   entry_type       wr_ent_ff, wr_ent_in;
   logic            rm_pend_ff, rm_pend_in, inc_ff, inc_in;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     res_ff, res_in;

   logic            mem_we;
   logic [IW-1:0]   mem_widx, mem_ridx;
   entry_type       mem_wdata, rd_data;

   bfra_table #(.DEPTH(MAX_RANGES)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_widx),
      .wr_data (mem_wdata),
      .rd_idx  (mem_ridx),
      .rd_data (rd_data)
   );

   // free: evaluation of entry i with neighbors
   logic            ev_state;
   logic [IW-1:0]   i_idx;
   logic [31:0]     cur_end, prev_end;
   logic            has_prev, hit_front, hit_back, merge_prev, merge_next, go_insert;
   logic [CW-1:0]   ins_pos;

   always_comb begin
      ev_state   = (state_ff == S_SCAN_EV);
      i_idx      = ev_state ? (j_ff[IW-1:0] - IW'(1)) : (cnt_ff[IW-1:0] - IW'(1));
      cur_end    = cur_ff.start + cur_ff.length;
      prev_end   = prev_ff.start + prev_ff.length;
      has_prev   = (i_idx != '0);
      hit_front  = (end_ff == cur_ff.start);
      hit_back   = (cur_end == addr_ff);
      merge_prev = has_prev && (prev_end == addr_ff);
      merge_next = ev_state && (end_ff == rd_data.start);
      go_insert  = !ev_state || ((i_idx == '0) && (addr_ff < cur_ff.start)) ||
                   ((cur_end < addr_ff) && (rd_data.start > addr_ff));
      if (pos_found_ff) begin
         ins_pos = pos_ff;
      end else if (ev_state) begin
         ins_pos = j_ff;
      end else begin
         ins_pos = cnt_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      done_in      = 1'b0;
      init_in      = init_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      pos_found_in = pos_found_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      k_in         = k_ff;
      rm_idx_in    = rm_idx_ff;
      wr_idx_in    = wr_idx_ff;
      wr_ent_in    = wr_ent_ff;
      rm_pend_in   = rm_pend_ff;
      inc_in       = inc_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_widx     = wr_idx_ff;
      mem_wdata    = wr_ent_ff;
      mem_ridx     = j_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in        = req_operation;
               size_in      = req_size;
               addr_in      = req_address;
               end_in       = req_address + req_size;
               status_in    = ST_OK;
               res_in       = '0;
               j_in         = '0;
               found_in     = 1'b0;
               pos_found_in = 1'b0;
               rm_pend_in   = 1'b0;
               inc_in       = 1'b0;
               if (req_operation == OP_ALLOC) begin
                  if (!init_ff) begin
                     state_in = S_INIT;
                  end else if (cnt_ff == '0) begin
                     status_in = ST_NOFIT;
                     done_in   = 1'b1;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end else if (cnt_ff == '0) begin
                  wr_idx_in = '0;
                  wr_ent_in = '{start: req_address, length: req_size};
                  inc_in    = 1'b1;
                  state_in  = S_WRITE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_INIT: begin
            mem_we    = 1'b1;
            mem_widx  = '0;
            mem_wdata = '{start: base_ff, length: size_cfg_ff};
            cnt_in    = CW'(1);
            init_in   = 1'b1;
            state_in  = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            mem_ridx = j_ff[IW-1:0];
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (op_ff == OP_ALLOC) begin
               if ((rd_data.length >= size_ff) &&
                   (!found_ff || (best_ff.length > rd_data.length))) begin
                  best_in     = rd_data;
                  best_idx_in = j_ff[IW-1:0];
                  found_in    = 1'b1;
               end
               if (((rd_data.length == size_ff)) || (j_ff + CW'(1) == cnt_ff)) begin
                  state_in = S_ALLOC_END;
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (!pos_found_ff && (rd_data.start > addr_ff)) begin
                  pos_in       = j_ff;
                  pos_found_in = 1'b1;
               end
               if (j_ff != '0 && hit_front) begin
                  state_in = S_WRITE;
                  if (merge_prev) begin
                     wr_idx_in  = i_idx - IW'(1);
                     wr_ent_in  = '{start: prev_ff.start,
                                    length: prev_ff.length + cur_ff.length + size_ff};
                     rm_idx_in  = i_idx;
                     rm_pend_in = 1'b1;
                  end else begin
                     wr_idx_in = i_idx;
                     wr_ent_in = '{start: addr_ff, length: cur_ff.length + size_ff};
                  end
               end else if (j_ff != '0 && hit_back) begin
                  state_in  = S_WRITE;
                  wr_idx_in = i_idx;
                  if (merge_next) begin
                     wr_ent_in  = '{start: cur_ff.start,
                                    length: cur_ff.length + size_ff + rd_data.length};
                     rm_idx_in  = j_ff[IW-1:0];
                     rm_pend_in = 1'b1;
                  end else begin
                     wr_ent_in = '{start: cur_ff.start, length: cur_ff.length + size_ff};
                  end
               end else if (j_ff != '0 && go_insert) begin
                  if (cnt_ff == CNT_MAX) begin
                     status_in = ST_FULL;
                     done_in   = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     pos_in    = ins_pos;
                     wr_idx_in = ins_pos[IW-1:0];
                     wr_ent_in = '{start: addr_ff, length: size_ff};
                     inc_in    = 1'b1;
                     k_in      = cnt_ff[IW-1:0];
                     state_in  = (ins_pos == cnt_ff) ? S_WRITE : S_INS_RD;
                  end
               end else begin
                  prev_in = cur_ff;
                  cur_in  = rd_data;
                  if (j_ff + CW'(1) == cnt_ff) begin
                     state_in = S_FREE_LAST;
                  end else begin
                     j_in     = j_ff + CW'(1);
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_FREE_LAST: begin
            state_in = S_WRITE;
            if (hit_front) begin
               if (merge_prev) begin
                  wr_idx_in  = i_idx - IW'(1);
                  wr_ent_in  = '{start: prev_ff.start,
                                 length: prev_ff.length + cur_ff.length + size_ff};
                  rm_idx_in  = i_idx;
                  rm_pend_in = 1'b1;
               end else begin
                  wr_idx_in = i_idx;
                  wr_ent_in = '{start: addr_ff, length: cur_ff.length + size_ff};
               end
            end else if (hit_back) begin
               wr_idx_in = i_idx;
               wr_ent_in = '{start: cur_ff.start, length: cur_ff.length + size_ff};
            end else if (cnt_ff == CNT_MAX) begin
               status_in = ST_FULL;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               pos_in    = ins_pos;
               wr_idx_in = ins_pos[IW-1:0];
               wr_ent_in = '{start: addr_ff, length: size_ff};
               inc_in    = 1'b1;
               k_in      = cnt_ff[IW-1:0];
               state_in  = (ins_pos == cnt_ff) ? S_WRITE : S_INS_RD;
            end
         end
         S_ALLOC_END: begin
            if (!found_ff) begin
               status_in = ST_NOFIT;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else if (best_ff.length == size_ff) begin
               res_in    = best_ff.start;
               rm_idx_in = best_idx_ff;
               state_in  = S_RM_BEGIN;
            end else begin
               wr_idx_in = best_idx_ff;
               wr_ent_in = '{start: best_ff.start, length: best_ff.length - size_ff};
               res_in    = best_ff.start + (best_ff.length - size_ff);
               state_in  = S_WRITE;
            end
         end
         S_WRITE: begin
            mem_we = 1'b1;
            if (inc_ff) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (rm_pend_ff) begin
               state_in = S_RM_BEGIN;
            end else begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RM_BEGIN: begin
            k_in = rm_idx_ff;
            if (CW'(rm_idx_ff) + CW'(1) == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RM_RD;
            end
         end
         S_RM_RD: begin
            mem_ridx = k_ff + IW'(1);
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            mem_we    = 1'b1;
            mem_widx  = k_ff;
            mem_wdata = rd_data;
            if (CW'(k_ff) + CW'(2) == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_RM_RD;
            end
         end
         S_INS_RD: begin
            mem_ridx = k_ff - IW'(1);
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_widx  = k_ff;
            mem_wdata = rd_data;
            k_in      = k_ff - IW'(1);
            // the word just moved came from the insert slot, which is now free to write
            state_in  = (CW'(k_ff) == pos_ff + CW'(1)) ? S_WRITE : S_INS_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         done_ff     <= 1'b0;
         init_ff     <= 1'b0;
         cnt_ff      <= '0;
         base_ff     <= '0;
         size_cfg_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         init_ff  <= init_in;
         cnt_ff   <= cnt_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE: base_ff     <= csr_wdata;
               CSR_SIZE: size_cfg_ff <= csr_wdata;
               default:  base_ff     <= base_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      pos_ff       <= pos_in;
      pos_found_ff <= pos_found_in;
      op_ff        <= op_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      found_ff     <= found_in;
      k_ff         <= k_in;
      rm_idx_ff    <= rm_idx_in;
      wr_idx_ff    <= wr_idx_in;
      wr_ent_ff    <= wr_ent_in;
      rm_pend_ff   <= rm_pend_in;
      inc_ff       <= inc_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_address_res = res_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX) else $error("range count above table depth");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid)) else $error("accepted word not taken up");

   a_idle_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("answer word while still busy");

   a_init_sticky: assert property (@(posedge clock) disable iff (reset)
      init_ff |=> init_ff) else $error("table load flag dropped");

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for best_fit_range_allocator. A queue of allocate and
// free words feeds a start/busy driver. Every word is run through a local
// best-fit table model as it is queued, and the answer words are checked in
// order.
// ---------------------------------------------------------------------------
module testbench import bfra_pkg::*; ();

   localparam int TABLE_DEPTH = DEFAULT_MAX_RANGES;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        op;
      logic [31:0] size;
      logic [31:0] addr;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] addr;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_BASE;
   logic [31:0] csr_wdata = '0;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_ALLOC;
   logic [31:0] req_size = '0;
   logic [31:0] req_address = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_address_res;

   best_fit_range_allocator dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_size(req_size), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_address_res(rsp_address_res)
   );

   always #5 clock = ~clock;

   // free-range table model
   logic [31:0] free_start [TABLE_DEPTH];
   logic [31:0] free_len [TABLE_DEPTH];
   int          free_count = 0;
   bit          area_loaded = 1'b0;
   logic [31:0] area_base = '0;
   logic [31:0] area_size = '0;

   request_type pending_words[$];
   answer_type  expected_answers[$];
   logic [31:0] live_addr[$];
   logic [31:0] live_size[$];

   int  idle_pct = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   bit  took = 1'b0;

   task automatic drop_range(input int idx);
      for (int k = idx; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k + 1];
         free_len[k] = free_len[k + 1];
      end
      free_count--;
   endtask

   task automatic add_range(input logic [31:0] addr, input logic [31:0] len,
                            output logic [1:0] status);
      int pos;
      pos = 0;
      if (free_count >= TABLE_DEPTH) begin
         status = ST_FULL;
         return;
      end
      while (pos < free_count && free_start[pos] <= addr) pos++;
      for (int k = free_count; k > pos; k--) begin
         free_start[k] = free_start[k - 1];
         free_len[k] = free_len[k - 1];
      end
      free_start[pos] = addr;
      free_len[pos] = len;
      free_count++;
      status = ST_OK;
   endtask

   task automatic take_range(input logic [31:0] size, output answer_type ans);
      int  best;
      bit  found;
      best = 0;
      found = 1'b0;
      ans.status = ST_NOFIT;
      ans.addr = '0;
      if (!area_loaded) begin
         free_start[0] = area_base;
         free_len[0] = area_size;
         free_count = 1;
         area_loaded = 1'b1;
      end
      for (int i = 0; i < free_count; i++) begin
         if (free_len[i] >= size && (!found || free_len[best] > free_len[i])) begin
            best = i;
            found = 1'b1;
            if (free_len[i] == size) break;
         end
      end
      if (!found) return;
      ans.status = ST_OK;
      if (free_len[best] == size) begin
         ans.addr = free_start[best];
         drop_range(best);
      end else begin
         free_len[best] = free_len[best] - size;
         ans.addr = free_start[best] + free_len[best];
      end
   endtask

   task automatic return_range(input logic [31:0] addr, input logic [31:0] size,
                               output logic [1:0] status);
      logic [31:0] stop;
      logic [31:0] cur_end;
      bit          last;
      stop = addr + size;
      if (free_count == 0) begin
         add_range(addr, size, status);
         return;
      end
      for (int i = 0; i < free_count; i++) begin
         cur_end = free_start[i] + free_len[i];
         last = (i + 1 >= free_count);
         if (stop == free_start[i]) begin
            free_start[i] = addr;
            free_len[i] = free_len[i] + size;
            if (i > 0 && free_start[i - 1] + free_len[i - 1] == free_start[i]) begin
               free_len[i - 1] = free_len[i - 1] + free_len[i];
               drop_range(i);
            end
            status = ST_OK;
            return;
         end
         if (cur_end == addr) begin
            free_len[i] = free_len[i] + size;
            if (!last && free_start[i] + free_len[i] == free_start[i + 1]) begin
               free_len[i] = free_len[i] + free_len[i + 1];
               drop_range(i + 1);
            end
            status = ST_OK;
            return;
         end
         if (last || (i == 0 && addr < free_start[0]) ||
             (cur_end < addr && free_start[i + 1] > addr)) begin
            add_range(addr, size, status);
            return;
         end
      end
      add_range(addr, size, status);
   endtask

   // predict and queue one word
   task automatic push_word(input logic op, input logic [31:0] size, input logic [31:0] addr);
      request_type w;
      answer_type  ans;
      w.op = op;
      w.size = size;
      w.addr = addr;
      if (op == OP_ALLOC) begin
         take_range(size, ans);
         if (ans.status == ST_OK) begin
            live_addr.push_back(ans.addr);
            live_size.push_back(size);
         end
      end else begin
         ans.addr = '0;
         return_range(addr, size, ans.status);
      end
      pending_words.push_back(w);
      expected_answers.push_back(ans);
   endtask

   task automatic free_live(input int idx);
      logic [31:0] a;
      logic [31:0] s;
      a = live_addr[idx];
      s = live_size[idx];
      live_addr.delete(idx);
      live_size.delete(idx);
      push_word(OP_FREE, s, a);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_BASE) area_base = value;
      else area_size = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (pending_words.size() != 0 || expected_answers.size() != 0 || start || busy)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      took <= start && !busy;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      request_type w;
      if (!reset && (!start || took)) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            req_operation <= w.op;
            req_size <= w.size;
            req_address <= w.addr;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type ans;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("answer word with nothing expected: status %0d addr %h",
                   rsp_status, rsp_address_res);
            error_count++;
         end else begin
            ans = expected_answers.pop_front();
            if (rsp_status !== ans.status) begin
               $error("status: expected %0d, got %0d", ans.status, rsp_status);
               error_count++;
            end
            if (rsp_address_res !== ans.addr) begin
               $error("address_res: expected %h, got %h", ans.addr, rsp_address_res);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase_idle [5];
      int pick;
      int r;
      logic [31:0] sz;

      phase_idle = '{0, 72, 0, 32, 15};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // only the values present at the first allocate count
      write_csr(CSR_BASE, 32'h0000_0000);
      write_csr(CSR_SIZE, 32'h0000_0000);
      write_csr(CSR_BASE, 32'hFFFF_FFFF);
      write_csr(CSR_SIZE, 32'hFFFF_FFFF);
      write_csr(CSR_BASE, 32'hFFFF_F000);   // area wraps past zero
      write_csr(CSR_SIZE, 32'h0001_0000);

      // frees before the area is loaded, then the reload drops them
      push_word(OP_FREE, 32'h0000_0010, 32'h0000_0100);
      push_word(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'h0000_0040, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
      push_word(OP_ALLOC, 32'h0, 32'h0);
      push_word(OP_ALLOC, 32'h10, 32'h0);
      push_word(OP_ALLOC, 32'h10, 32'h0);
      push_word(OP_ALLOC, 32'h10, 32'h0);
      free_live(3);                       // middle block: new entry
      free_live(3);                       // joins from below, merges
      free_live(0);
      // spread-out frees fill the table until it reports full
      for (int k = 0; k < 16; k++)
         push_word(OP_FREE, 32'h8, 32'h4000_0000 + k * 32'h100);
      drain();

      for (int p = 0; p < 5; p++) begin
         idle_pct = phase_idle[p];
         for (int n = 0; n < 200; n++) begin
            r = $urandom_range(99);
            if (r < 5) begin
               push_word(OP_FREE, $urandom, $urandom);
            end else if (r < 50 && live_addr.size() != 0) begin
               pick = $urandom_range(live_addr.size() - 1);
               free_live(pick);
            end else begin
               r = $urandom_range(99);
               if (r < 3) sz = '0;
               else if (r < 8) sz = $urandom;
               else sz = $urandom_range(1, 512);
               push_word(OP_ALLOC, sz, $urandom);
            end
         end
         drain();
         write_csr(CSR_BASE, (p % 2) ? 32'hFFFF_FFFF : $urandom);
         write_csr(CSR_SIZE, (p % 2) ? 32'h0 : $urandom);
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

### best_fit_range_allocator.f
rtl/core/bfra_pkg.sv
rtl/core/bfra_table.sv
rtl/core/best_fit_range_allocator.sv
sim/testbench.sv
